[rtl/core/ffha_pkg.sv]
// Constants and types shared by the first-fit heap allocator.
package ffha_pkg;

   localparam int HEAP_BYTES      = 1024;
   localparam int GRANULE_BYTES   = 16;
   localparam int NUM_GRANULES    = HEAP_BYTES / GRANULE_BYTES;
   localparam int GRAN_SHIFT      = $clog2(GRANULE_BYTES);
   localparam int GRAN_W          = $clog2(NUM_GRANULES);
   localparam int IDX_W           = GRAN_W + 1;
   localparam int TOO_LARGE_LIMIT = HEAP_BYTES - GRANULE_BYTES;
   localparam int ADDR_W          = 10;
   localparam int BYTES_W         = 16;
   localparam int STATUS_W        = 2;

   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NO_FIT    = 2'd1;
   localparam logic [STATUS_W-1:0] ST_TOO_LARGE = 2'd2;
   localparam logic [STATUS_W-1:0] ST_BAD_FREE  = 2'd3;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   typedef struct packed {
      logic              start;
      logic              used;
      logic [GRAN_W-1:0] size;
   } entry_type;

   localparam entry_type ENTRY_FIRST = '{start: 1'b1, used: 1'b0,
                                         size: GRAN_W'(NUM_GRANULES - 1)};
   localparam entry_type ENTRY_CLEAR = '{start: 1'b0, used: 1'b0, size: '0};

endpackage

[rtl/core/first_fit_heap_allocator.sv]
// First-fit heap allocator with free-list coalescing over a block table.
//
// Usage: the request channel (req_) carries one operation per beat; req_tuser
// selects allocate or free. The response channel (rsp_) returns exactly one
// beat per request with a status code and, for a successful allocate, the
// payload byte offset. The block serves one request at a time and holds
// req_tready low while it works.
// Sequencing: the block table sits in a memory with one write port and a
// registered read port, and one sequencer walks it. An allocate reads and checks
// each block header in turn, then writes the rest header, if any, and the granted
// header; a too-large request goes straight to the response. A free checks its
// header and clears its used bit, then a merge pass joins free neighbours.
// Reset: the heap becomes one free block covering every granule after the
// first header; the table holds per-entry valid bits, so no clearing pass runs.
// Stalls: the result waits in an output register. A new request may be taken
// while it waits, but its own result is held back until rsp_tready frees the
// register.
module first_fit_heap_allocator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // request_bytes[15:0], free_address[25:16], zero
   input  logic [0:0]  req_tuser,  // op[0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata   // status[1:0], payload_address[11:2], zero
);

   localparam int NG  = ffha_pkg::NUM_GRANULES;
   localparam int GW  = ffha_pkg::GRAN_W;
   localparam int IW  = ffha_pkg::IDX_W;
   localparam int AW  = ffha_pkg::ADDR_W;
   localparam int GS  = ffha_pkg::GRAN_SHIFT;
   localparam int SW  = ffha_pkg::STATUS_W;
   localparam int BYTES_W_L = ffha_pkg::BYTES_W;

   localparam logic [3:0] S_IDLE      = 4'd0;
   localparam logic [3:0] S_A_RD      = 4'd1;
   localparam logic [3:0] S_A_CHK     = 4'd2;
   localparam logic [3:0] S_A_WR_REST = 4'd3;
   localparam logic [3:0] S_A_WR_HDR  = 4'd4;
   localparam logic [3:0] S_F_RD      = 4'd5;
   localparam logic [3:0] S_F_CHK     = 4'd6;
   localparam logic [3:0] S_C_RD      = 4'd7;
   localparam logic [3:0] S_C_G       = 4'd8;
   localparam logic [3:0] S_C_N       = 4'd9;
   localparam logic [3:0] S_C_CLR     = 4'd10;
   localparam logic [3:0] S_RESP      = 4'd11;

   ffha_pkg::entry_type table_ff [NG];
   ffha_pkg::entry_type rd_entry_ff;
   logic                rd_valid_ff;
   logic                rd_zero_ff;
   logic [NG-1:0]       valid_ff;

   logic [3:0]          state_ff, state_in;
   logic [IW-1:0]       g_ff, g_in;
   logic [IW-1:0]       nxt_ff, nxt_in;
   logic [IW-1:0]       rest_ff, rest_in;
   logic [GW-1:0]       need_ff, need_in;
   ffha_pkg::entry_type cur_ff, cur_in;
   ffha_pkg::entry_type rest_e_ff, rest_e_in;
   logic [SW-1:0]       status_ff, status_in;
   logic [AW-1:0]       addr_ff, addr_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [15:0]         rsp_data_ff, rsp_data_in;

   logic                wr_en;
   logic [GW-1:0]       wr_addr;
   ffha_pkg::entry_type wr_data;
   logic [GW-1:0]       rd_addr;
   ffha_pkg::entry_type entry;

   logic [BYTES_W_L-1:0] req_bytes;
   logic [AW-1:0]        req_free;
   logic [16:0]          bytes_up;
   logic [31:0]          free_gran;
   logic [IW-1:0]        walk_nxt;
   logic [IW-1:0]        rest_idx;
   logic [31:0]          pay_full;

   assign req_bytes = req_tdata[BYTES_W_L-1:0];
   assign req_free  = req_tdata[BYTES_W_L+AW-1:BYTES_W_L];
   assign bytes_up  = 17'(req_bytes) + 17'(ffha_pkg::GRANULE_BYTES - 1);
   assign free_gran = 32'(req_free >> GS);

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign entry = rd_valid_ff ? rd_entry_ff
                : (rd_zero_ff ? ffha_pkg::ENTRY_FIRST : ffha_pkg::ENTRY_CLEAR);

   assign walk_nxt = g_ff + IW'(1) + IW'(entry.size);
   assign rest_idx = g_ff + IW'(1) + IW'(need_ff);
   assign pay_full = 32'(g_ff + IW'(1)) << GS;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_ff[wr_addr] <= wr_data;
      end
      rd_entry_ff <= table_ff[rd_addr];
      rd_valid_ff <= valid_ff[rd_addr];
      rd_zero_ff  <= (rd_addr == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_comb begin
      state_in     = state_ff;
      g_in         = g_ff;
      nxt_in       = nxt_ff;
      rest_in      = rest_ff;
      need_in      = need_ff;
      cur_in       = cur_ff;
      rest_e_in    = rest_e_ff;
      status_in    = status_ff;
      addr_in      = addr_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in  = rsp_data_ff;
      wr_en        = 1'b0;
      wr_addr      = g_ff[GW-1:0];
      wr_data      = cur_ff;
      rd_addr      = g_ff[GW-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               status_in = ffha_pkg::ST_OK;
               addr_in   = '0;
               g_in      = '0;
               if (req_tuser[0] == ffha_pkg::OP_ALLOC) begin
                  need_in = GW'(bytes_up >> GS);
                  if (32'(req_bytes) > 32'(ffha_pkg::TOO_LARGE_LIMIT)) begin
                     status_in = ffha_pkg::ST_TOO_LARGE;
                     state_in  = S_RESP;
                  end else begin
                     state_in = S_A_RD;
                  end
               end else begin
                  if (req_free[GS-1:0] != '0 || 32'(req_free) < 32'(ffha_pkg::GRANULE_BYTES)
                      || (free_gran - 32'd1) >= 32'(NG)) begin
                     status_in = ffha_pkg::ST_BAD_FREE;
                     state_in  = S_RESP;
                  end else begin
                     g_in     = IW'(free_gran - 32'd1);
                     state_in = S_F_RD;
                  end
               end
            end
         end
         S_A_RD: begin
            if (32'(g_ff) >= 32'(NG)) begin
               status_in = ffha_pkg::ST_NO_FIT;
               state_in  = S_RESP;
            end else begin
               state_in = S_A_CHK;
            end
         end
         S_A_CHK: begin
            if (!entry.start) begin
               status_in = ffha_pkg::ST_NO_FIT;
               state_in  = S_RESP;
            end else if (!entry.used && entry.size >= need_ff) begin
               cur_in      = entry;
               cur_in.used = 1'b1;
               addr_in     = pay_full[AW-1:0];
               rest_in     = rest_idx;
               rest_e_in   = '{start: 1'b1, used: 1'b0, size: entry.size - need_ff - GW'(1)};
               if ((IW'(entry.size) > IW'(need_ff) + IW'(1)) && (32'(rest_idx) < 32'(NG))) begin
                  cur_in.size = need_ff;
                  state_in    = S_A_WR_REST;
               end else begin
                  state_in = S_A_WR_HDR;
               end
            end else begin
               g_in     = walk_nxt;
               state_in = S_A_RD;
            end
         end
         S_A_WR_REST: begin
            wr_en    = 1'b1;
            wr_addr  = rest_ff[GW-1:0];
            wr_data  = rest_e_ff;
            state_in = S_A_WR_HDR;
         end
         S_A_WR_HDR: begin
            wr_en    = 1'b1;
            state_in = S_RESP;
         end
         S_F_RD: begin
            state_in = S_F_CHK;
         end
         S_F_CHK: begin
            if (!entry.start || !entry.used) begin
               status_in = ffha_pkg::ST_BAD_FREE;
               state_in  = S_RESP;
            end else begin
               wr_en        = 1'b1;
               wr_data      = entry;
               wr_data.used = 1'b0;
               g_in         = '0;
               state_in     = S_C_RD;
            end
         end
         S_C_RD: begin
            if (32'(g_ff) >= 32'(NG)) begin
               state_in = S_RESP;
            end else begin
               state_in = S_C_G;
            end
         end
         S_C_G: begin
            cur_in  = entry;
            nxt_in  = walk_nxt;
            rd_addr = walk_nxt[GW-1:0];
            if (!entry.start || 32'(walk_nxt) >= 32'(NG)) begin
               state_in = S_RESP;
            end else begin
               state_in = S_C_N;
            end
         end
         S_C_N: begin
            if (!entry.start) begin
               state_in = S_RESP;
            end else if (!cur_ff.used && !entry.used) begin
               wr_en        = 1'b1;
               wr_data      = cur_ff;
               wr_data.size = cur_ff.size + entry.size + GW'(1);
               state_in     = S_C_CLR;
            end else begin
               g_in     = nxt_ff;
               state_in = S_C_RD;
            end
         end
         S_C_CLR: begin
            wr_en    = 1'b1;
            wr_addr  = nxt_ff[GW-1:0];
            wr_data  = ffha_pkg::ENTRY_CLEAR;
            state_in = S_C_RD;
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = 16'({addr_ff, status_ff});
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      g_ff        <= g_in;
      nxt_ff      <= nxt_in;
      rest_ff     <= rest_in;
      need_ff     <= need_in;
      cur_ff      <= cur_in;
      rest_e_ff   <= rest_e_in;
      status_ff   <= status_in;
      addr_ff     <= addr_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

[sim/first_fit_heap_allocator_tb.sv]
// Self-checking testbench for the first-fit heap allocator: directed and random requests.
`timescale 1ns / 100ps

module first_fit_heap_allocator_tb;

   localparam int  SCRIPT_LEN   = 23;
   localparam int  RANDOM_ITEMS = 600;
   localparam int  QUIET_TAIL   = 80;
   localparam int  HOLD_CYCLES  = 400;
   localparam logic KNOWN       = 1'b1;
   localparam logic PREDICT     = 1'b0;
   localparam int  NG           = ffha_pkg::NUM_GRANULES;
   localparam int  GW           = ffha_pkg::GRAN_W;
   localparam int  AW           = ffha_pkg::ADDR_W;
   localparam int  BW           = ffha_pkg::BYTES_W;
   localparam int  SW           = ffha_pkg::STATUS_W;
   localparam int  GB           = ffha_pkg::GRANULE_BYTES;
   localparam int  LIMIT        = ffha_pkg::TOO_LARGE_LIMIT;

   typedef struct packed {
      logic [SW-1:0] status;
      logic [AW-1:0] payload;
   } reply_type;

   typedef struct packed {
      logic          op;
      logic [BW-1:0] bytes;
      logic [AW-1:0] addr;
      logic          typed;
      logic [SW-1:0] status;
      logic [AW-1:0] payload;
   } script_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic [0:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;

   ffha_pkg::entry_type heap_map [NG];
   reply_type   pending_replies [$];
   logic [AW-1:0] live_blocks [$];
   int          fault_count = 0;
   int          cycle_count = 0;
   bit          quiet = 1'b0;
   bit          hold_wanted = 1'b0;

   script_row_type plan [SCRIPT_LEN] = '{
      '{ffha_pkg::OP_ALLOC, 16'd0,     10'd0,    KNOWN,   ffha_pkg::ST_OK,        10'd16},
      '{ffha_pkg::OP_ALLOC, 16'd1009,  10'd0,    KNOWN,   ffha_pkg::ST_TOO_LARGE, 10'd0},
      '{ffha_pkg::OP_ALLOC, 16'd65535, 10'd1023, KNOWN,   ffha_pkg::ST_TOO_LARGE, 10'd0},
      '{ffha_pkg::OP_FREE,  16'd0,     10'd0,    KNOWN,   ffha_pkg::ST_BAD_FREE,  10'd0},
      '{ffha_pkg::OP_FREE,  16'd65535, 10'd8,    KNOWN,   ffha_pkg::ST_BAD_FREE,  10'd0},
      '{ffha_pkg::OP_FREE,  16'd0,     10'd1023, KNOWN,   ffha_pkg::ST_BAD_FREE,  10'd0},
      '{ffha_pkg::OP_ALLOC, 16'd1008,  10'd0,    KNOWN,   ffha_pkg::ST_NO_FIT,    10'd0},
      '{ffha_pkg::OP_FREE,  16'd0,     10'd16,   KNOWN,   ffha_pkg::ST_OK,        10'd0},
      '{ffha_pkg::OP_ALLOC, 16'd1008,  10'd0,    KNOWN,   ffha_pkg::ST_OK,        10'd16},
      '{ffha_pkg::OP_ALLOC, 16'd1,     10'd0,    KNOWN,   ffha_pkg::ST_NO_FIT,    10'd0},
      '{ffha_pkg::OP_FREE,  16'd0,     10'd16,   KNOWN,   ffha_pkg::ST_OK,        10'd0},
      '{ffha_pkg::OP_ALLOC, 16'd1,     10'd0,    PREDICT, ffha_pkg::ST_OK,        10'd0},
      '{ffha_pkg::OP_FREE,  16'd0,     10'd32,   KNOWN,   ffha_pkg::ST_BAD_FREE,  10'd0},
      '{ffha_pkg::OP_ALLOC, 16'd17,    10'd0,    PREDICT, ffha_pkg::ST_OK,        10'd0},
      '{ffha_pkg::OP_ALLOC, 16'd16,    10'd0,    PREDICT, ffha_pkg::ST_OK,        10'd0},
      '{ffha_pkg::OP_FREE,  16'd0,     10'd48,   PREDICT, ffha_pkg::ST_OK,        10'd0},
      '{ffha_pkg::OP_FREE,  16'd0,     10'd48,   KNOWN,   ffha_pkg::ST_BAD_FREE,  10'd0},
      '{ffha_pkg::OP_ALLOC, 16'd16,    10'd0,    PREDICT, ffha_pkg::ST_OK,        10'd0},
      '{ffha_pkg::OP_ALLOC, 16'd0,     10'd0,    PREDICT, ffha_pkg::ST_OK,        10'd0},
      '{ffha_pkg::OP_FREE,  16'd0,     10'd96,   PREDICT, ffha_pkg::ST_OK,        10'd0},
      '{ffha_pkg::OP_FREE,  16'd0,     10'd16,   PREDICT, ffha_pkg::ST_OK,        10'd0},
      '{ffha_pkg::OP_FREE,  16'd0,     10'd48,   PREDICT, ffha_pkg::ST_OK,        10'd0},
      '{ffha_pkg::OP_ALLOC, 16'd1000,  10'd0,    PREDICT, ffha_pkg::ST_OK,        10'd0}
   };

   first_fit_heap_allocator uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic void reset_heap_map();
      foreach (heap_map[i]) heap_map[i] = ffha_pkg::ENTRY_CLEAR;
      heap_map[0] = ffha_pkg::ENTRY_FIRST;
   endfunction

   function automatic void merge_free_neighbours();
      int g;
      int nxt;
      g = 0;
      while (g < NG && heap_map[g].start) begin
         nxt = g + 1 + int'(heap_map[g].size);
         if (nxt >= NG || !heap_map[nxt].start) break;
         if (!heap_map[g].used && !heap_map[nxt].used) begin
            heap_map[g].size = GW'(int'(heap_map[g].size) + int'(heap_map[nxt].size) + 1);
            heap_map[nxt] = ffha_pkg::ENTRY_CLEAR;
         end else begin
            g = nxt;
         end
      end
   endfunction

   function automatic reply_type first_fit_grant(logic [BW-1:0] bytes);
      reply_type r;
      int need;
      int g;
      int rest;
      int avail;
      r.status  = ffha_pkg::ST_OK;
      r.payload = '0;
      if (int'(bytes) > LIMIT) begin
         r.status = ffha_pkg::ST_TOO_LARGE;
         return r;
      end
      need = (int'(bytes) + GB - 1) / GB;
      g = 0;
      while (g < NG && heap_map[g].start) begin
         avail = int'(heap_map[g].size);
         if (!heap_map[g].used && avail >= need) begin
            rest = g + 1 + need;
            if (avail > need + 1 && rest < NG) begin
               heap_map[rest].start = 1'b1;
               heap_map[rest].used  = 1'b0;
               heap_map[rest].size  = GW'(avail - need - 1);
               heap_map[g].size     = GW'(need);
            end
            heap_map[g].used = 1'b1;
            r.payload = AW'((g + 1) * GB);
            return r;
         end
         g = g + 1 + avail;
      end
      r.status = ffha_pkg::ST_NO_FIT;
      return r;
   endfunction

   function automatic reply_type release_block(logic [AW-1:0] addr);
      reply_type r;
      int g;
      r.status  = ffha_pkg::ST_BAD_FREE;
      r.payload = '0;
      if (int'(addr) % GB != 0 || int'(addr) < GB) return r;
      g = int'(addr) / GB - 1;
      if (g >= NG || !heap_map[g].start || !heap_map[g].used) return r;
      heap_map[g].used = 1'b0;
      merge_free_neighbours();
      r.status = ffha_pkg::ST_OK;
      return r;
   endfunction

   // Holds one request on the bus until it is taken, then advances the heap picture.
   task automatic offer_request(input logic op, input logic [BW-1:0] bytes,
                                input logic [AW-1:0] addr, output reply_type predicted);
      req_tvalid <= 1'b1;
      req_tdata  <= {6'b0, addr, bytes};
      req_tuser  <= op;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (op == ffha_pkg::OP_ALLOC) predicted = first_fit_grant(bytes);
      else predicted = release_block(addr);
   endtask

   task automatic sender_gap(input int index);
      if (!quiet && (index / 60) % 3 != 2 && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
   endtask

   initial begin
      reply_type predicted;
      logic op;
      logic [BW-1:0] bytes;
      logic [AW-1:0] addr;
      int pick;
      int slot;
      reset_heap_map();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < SCRIPT_LEN; i++) begin
         sender_gap(i);
         offer_request(plan[i].op, plan[i].bytes, plan[i].addr, predicted);
         if (plan[i].typed) pending_replies.push_back({plan[i].status, plan[i].payload});
         else pending_replies.push_back(predicted);
      end

      live_blocks.delete();
      for (int g = 0; g < NG; g++) begin
         if (heap_map[g].start && heap_map[g].used) live_blocks.push_back(AW'((g + 1) * GB));
      end

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         quiet = (i >= RANDOM_ITEMS - QUIET_TAIL);
         if (i == 150) hold_wanted = 1'b1;
         sender_gap(i);
         pick  = $urandom_range(0, 99);
         bytes = 16'($urandom_range(0, 65535));
         addr  = 10'($urandom_range(0, 1023));
         if (pick < 45 || live_blocks.size() == 0) begin
            op = ffha_pkg::OP_ALLOC;
            case ($urandom_range(0, 9))
               0, 1, 2, 3, 4, 5: bytes = 16'($urandom_range(0, 160));
               6, 7:             bytes = 16'($urandom_range(161, LIMIT));
               8:                ;
               default: begin
                  case ($urandom_range(0, 4))
                     0: bytes = 16'(LIMIT);
                     1: bytes = 16'(LIMIT + 1);
                     2: bytes = 16'd0;
                     3: bytes = 16'(GB);
                     default: bytes = 16'(GB + 1);
                  endcase
               end
            endcase
         end else begin
            op = ffha_pkg::OP_FREE;
            if (pick < 88) begin
               slot = $urandom_range(0, live_blocks.size() - 1);
               addr = live_blocks[slot];
            end
         end
         offer_request(op, bytes, addr, predicted);
         pending_replies.push_back(predicted);
         if (predicted.status == ffha_pkg::ST_OK) begin
            if (op == ffha_pkg::OP_ALLOC && predicted.payload != '0) begin
               live_blocks.push_back(predicted.payload);
            end else if (op == ffha_pkg::OP_FREE) begin
               foreach (live_blocks[k]) begin
                  if (live_blocks[k] == addr) begin
                     live_blocks.delete(k);
                     break;
                  end
               end
            end
         end
      end
      req_tvalid <= 1'b0;

      while (pending_replies.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (fault_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   initial begin
      int stall_left;
      bit hold_done;
      stall_left = 0;
      hold_done  = 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         cycle_count++;
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else if (hold_wanted && !hold_done) begin
            hold_done  = 1'b1;
            stall_left = HOLD_CYCLES - 1;
            rsp_tready <= 1'b0;
         end else if (!quiet && (cycle_count / 500) % 4 != 3 && $urandom_range(0, 11) == 0) begin
            stall_left = $urandom_range(1, 18) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      reply_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_replies.size() == 0) begin
            fault_count++;
            if (fault_count <= 10) $display("unexpected result beat: %h", rsp_tdata);
         end else begin
            want = pending_replies.pop_front();
            if (rsp_tdata[1:0] !== want.status || rsp_tdata[11:2] !== want.payload) begin
               fault_count++;
               if (fault_count <= 10) begin
                  $display("mismatch: status exp %0d got %0d, payload_address exp %0d got %0d",
                           want.status, rsp_tdata[1:0], want.payload, rsp_tdata[11:2]);
               end
            end
         end
      end
   end

   initial begin
      #2_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule

[sim.f]
rtl/core/ffha_pkg.sv
rtl/core/first_fit_heap_allocator.sv
sim/first_fit_heap_allocator_tb.sv
